// ===== design/pmq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the priority message queue.
package pmq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  action;
    logic [7:0]  first_command;
    logic [7:0]  first_key;
    logic [15:0] first_value;
    logic [7:0]  second_command;
    logic [7:0]  second_key;
    logic [15:0] second_value;
    logic [7:0]  delimiter;
  } msg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    msg_t       msg;
    logic [1:0] status;
    logic [3:0] count;
  } res_t;

endpackage

// ===== design/pmq_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port, one registered read port.
module pmq_mem #(
  parameter int unsigned DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  pmq_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     raddr_i,
  input  logic [AW-1:0]     waddr_i,
  input  pmq_pkg::msg_t     wdata_i,
  output pmq_pkg::msg_t     rdata_o
);

  pmq_pkg::msg_t mem_q [DEPTH];
  pmq_pkg::msg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pmq_ctrl.sv =====
`timescale 1ns / 1ps
// Queue sequencer: scans, ripples and shifts entries through the store.
module pmq_ctrl #(
  parameter int unsigned DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  pmq_pkg::msg_t     msg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pmq_pkg::res_t     res_o,
  output pmq_pkg::mem_ctl_t mem_ctl_o,
  output logic [AW-1:0]     raddr_o,
  output logic [AW-1:0]     waddr_o,
  output pmq_pkg::msg_t     wdata_o,
  input  pmq_pkg::msg_t     rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RIPPLE,
    S_POPH,
    S_POPSH,
    S_DONE
  } state_e;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_e        state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  pmq_pkg::msg_t msg_q, msg_d;
  pmq_pkg::msg_t carry_q, carry_d;
  pmq_pkg::msg_t res_msg_q, res_msg_d;
  logic [1:0]    status_q, status_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [CW:0]   idx_inc;
  logic [AW-1:0] idx_next;
  logic          has_more;
  logic          full;
  logic [CW+3:0] cnt_ext;

  assign idx_inc  = (CW + 1)'(idx_q) + 1'b1;
  assign idx_next = idx_inc[AW-1:0];
  assign has_more = idx_inc < {1'b0, cnt_q};
  assign full     = cnt_q >= DEPTH_C;
  assign cnt_ext  = {4'b0000, cnt_q};

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    msg_d     = msg_q;
    carry_d   = carry_q;
    res_msg_d = res_msg_q;
    status_d  = status_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    mem_ctl_o = '0;
    raddr_o   = '0;
    waddr_o   = '0;
    wdata_o   = msg_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          msg_d   = msg_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_msg_d = '0;
        status_d  = pmq_pkg::ST_OK;
        state_d   = S_DONE;
        unique case (cmd_q)
          pmq_pkg::CMD_APPEND: begin
            if (!full) begin
              mem_ctl_o.wr_en = 1'b1;
              waddr_o         = cnt_q[AW-1:0];
              cnt_d           = CW'(cnt_q + 1'b1);
            end else begin
              status_d = pmq_pkg::ST_DROPPED;
            end
          end
          pmq_pkg::CMD_INSERT: begin
            if (cnt_q == '0) begin
              mem_ctl_o.wr_en = 1'b1;
              waddr_o         = '0;
              cnt_d           = CW'(1);
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              raddr_o         = '0;
              idx_d           = '0;
              state_d         = S_SCAN;
            end
          end
          pmq_pkg::CMD_POP: begin
            if (cnt_q == '0) begin
              status_d = pmq_pkg::ST_EMPTY;
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              raddr_o         = '0;
              idx_d           = '0;
              state_d         = S_POPH;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        priority if (msg_q.prio < rdata_i.prio) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = idx_q;
          carry_d         = rdata_i;
          if (has_more) begin
            mem_ctl_o.rd_en = 1'b1;
            raddr_o         = idx_next;
            idx_d           = idx_next;
            state_d         = S_RIPPLE;
          end else begin
            state_d = S_DONE;
          end
        end else if (msg_q.prio == rdata_i.prio &&
                     msg_q.first_command == rdata_i.first_command &&
                     msg_q.second_command == rdata_i.second_command) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = idx_q;
          status_d        = pmq_pkg::ST_REPLACED;
          state_d         = S_DONE;
        end else if (has_more) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = idx_next;
          idx_d           = idx_next;
        end else begin
          state_d = S_DONE;
          if (!full) begin
            mem_ctl_o.wr_en = 1'b1;
            waddr_o         = cnt_q[AW-1:0];
            cnt_d           = CW'(cnt_q + 1'b1);
          end else begin
            status_d = pmq_pkg::ST_DROPPED;
          end
        end
      end
      S_RIPPLE: begin
        mem_ctl_o.wr_en = 1'b1;
        waddr_o         = idx_q;
        wdata_o         = carry_q;
        carry_d         = rdata_i;
        if (has_more) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = idx_next;
          idx_d           = idx_next;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POPH: begin
        res_msg_d = rdata_i;
        if (has_more) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = idx_next;
          idx_d           = idx_next;
          state_d         = S_POPSH;
        end else begin
          // last entry read out: an empty message takes the head, count stays unchanged
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = '0;
          wdata_o         = '0;
          state_d         = S_DONE;
        end
      end
      S_POPSH: begin
        mem_ctl_o.wr_en = 1'b1;
        waddr_o         = AW'(idx_q - 1'b1);
        wdata_o         = rdata_i;
        if (has_more) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = idx_next;
          idx_d           = idx_next;
        end else begin
          cnt_d   = CW'(cnt_q - 1'b1);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmd_q     <= '0;
      msg_q     <= '0;
      carry_q   <= '0;
      res_msg_q <= '0;
      status_q  <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmd_q     <= cmd_d;
      msg_q     <= msg_d;
      carry_q   <= carry_d;
      res_msg_q <= res_msg_d;
      status_q  <= status_d;
      idx_q     <= idx_d;
    end
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign res_valid_o  = state_q == S_DONE;
  assign res_o.msg    = res_msg_q;
  assign res_o.status = status_q;
  assign res_o.count  = cnt_ext[3:0];

endmodule

// ===== design/priority_message_queue_core.sv =====
`timescale 1ns / 1ps
// Priority message queue: top level with output register.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | cmd_i and message fields
//   out     | output    | out_valid_o / out_stall_i | popped message, count, status
//
// With no output stall the sequencer handles one store entry per cycle while it scans,
// ripples or shifts; append, insert into or pop of an empty queue and the unused code go
// straight from the execute state to the done state. Reset clears the sequencer registers
// and the output valid flag, but neither the store nor the output data register.
// A new item is taken while a result waits in the output register;
// the sequencer holds a finished result only if that register is full and out_stall_i is high.
module priority_message_queue_core #(
  parameter int unsigned QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  priority_req_i,
  input  logic [7:0]  action_i,
  input  logic [7:0]  first_command_i,
  input  logic [7:0]  first_key_i,
  input  logic [15:0] first_value_i,
  input  logic [7:0]  second_command_i,
  input  logic [7:0]  second_key_i,
  input  logic [15:0] second_value_i,
  input  logic [7:0]  delimiter_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_priority_o,
  output logic [7:0]  out_action_o,
  output logic [7:0]  out_first_command_o,
  output logic [7:0]  out_first_key_o,
  output logic [15:0] out_first_value_o,
  output logic [7:0]  out_second_command_o,
  output logic [7:0]  out_second_key_o,
  output logic [15:0] out_second_value_o,
  output logic [7:0]  out_delimiter_o,
  output logic [3:0]  queue_count_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0] DEPTH_LOW = 4'(QUEUE_DEPTH);

  pmq_pkg::msg_t     msg_in;
  pmq_pkg::res_t     res;
  pmq_pkg::res_t     out_res_q;
  pmq_pkg::mem_ctl_t mem_ctl;
  pmq_pkg::msg_t     wdata;
  pmq_pkg::msg_t     rdata;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_q;

  assign msg_in.prio           = priority_req_i;
  assign msg_in.action         = action_i;
  assign msg_in.first_command  = first_command_i;
  assign msg_in.first_key      = first_key_i;
  assign msg_in.first_value    = first_value_i;
  assign msg_in.second_command = second_command_i;
  assign msg_in.second_key     = second_key_i;
  assign msg_in.second_value   = second_value_i;
  assign msg_in.delimiter      = delimiter_i;

  pmq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .msg_i       (msg_in),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .raddr_o     (raddr),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .rdata_i     (rdata)
  );

  pmq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_priority_o       = out_res_q.msg.prio;
  assign out_action_o         = out_res_q.msg.action;
  assign out_first_command_o  = out_res_q.msg.first_command;
  assign out_first_key_o      = out_res_q.msg.first_key;
  assign out_first_value_o    = out_res_q.msg.first_value;
  assign out_second_command_o = out_res_q.msg.second_command;
  assign out_second_key_o     = out_res_q.msg.second_key;
  assign out_second_value_o   = out_res_q.msg.second_value;
  assign out_delimiter_o      = out_res_q.msg.delimiter;
  assign queue_count_o        = out_res_q.count;
  assign status_o             = out_res_q.status;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted but sequencer not busy");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pmq_pkg::ST_DROPPED |-> queue_count_o == DEPTH_LOW)
    else $error("item dropped while queue not full");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pmq_pkg::ST_EMPTY |->
      queue_count_o == 4'd0 && out_priority_o == 8'd0)
    else $error("empty pop with entries or data");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while output register full");
`endif

endmodule
